[rtl/ttq_pkg.sv]
package ttq_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_BATCH       = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int NS_PER_US       = 1000;
  localparam int DL_W            = 50;

  // action codes
  localparam logic [1:0] ACT_POST   = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_POSTED     = 3'd0;
  localparam logic [2:0] KIND_REJECTED   = 3'd1;
  localparam logic [2:0] KIND_CANCELLED  = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND  = 3'd3;
  localparam logic [2:0] KIND_FIRED      = 3'd4;
  localparam logic [2:0] KIND_TICK_IDLE  = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [47:0] now_time;
    logic [31:0] delay_us;
    logic [31:0] interval_us;
    logic        is_periodic;
    logic [31:0] run_limit;
    logic [31:0] cancel_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] task_id;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [DL_W-1:0] dl;
    logic [31:0]     num;
    logic            periodic;
    logic [31:0]     runs_done;
    logic [31:0]     runs_allowed;
    logic [31:0]     interval;
    logic            cancelled;
  } entry_t;

endpackage

[rtl/ttq_ram.sv]
module ttq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/timed_task_queue.sv]
// Timed task queue: a table of TABLE_DEPTH tasks, each keyed by a unique
// deadline in ns, held in one single-port-write RAM plus a used-bit vector.
// Every item goes through full passes over the table, one slot per cycle,
// behind the registered RAM read. A post makes one pass, plus one more per
// deadline collision. A cancel makes one pass. A tick makes one pass per
// visited task (fired, freed cancelled, plus the stop point) and then, per
// fired task that stays in the table, more passes to reschedule it.
// busy is high for the whole item; results come out marked by strobe, with
// last set on the final one, and the receiver cannot stall them.
module timed_task_queue #(
  parameter int TABLE_DEPTH = ttq_pkg::DEF_TABLE_DEPTH,
  parameter int BATCH       = ttq_pkg::DEF_BATCH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ttq_pkg::cmd_t    cmd,
  output logic             strobe,
  output ttq_pkg::result_t result
);
  import ttq_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int FIRE_LIMIT = (BATCH < MAX_RESULTS) ? BATCH : MAX_RESULTS;
  localparam int NW = $clog2(FIRE_LIMIT + 1);
  localparam int FW = (FIRE_LIMIT > 1) ? $clog2(FIRE_LIMIT) : 1;
  localparam int EW = $bits(entry_t);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_POST_MUL  = 12'b000000000010,
    S_POST_ADD  = 12'b000000000100,
    S_POST_SCAN = 12'b000000001000,
    S_POST_END  = 12'b000000010000,
    S_CAN_SCAN  = 12'b000000100000,
    S_CAN_END   = 12'b000001000000,
    S_WALK_SCAN = 12'b000010000000,
    S_WALK_END  = 12'b000100000000,
    S_RS_RD     = 12'b001000000000,
    S_RS_CAP    = 12'b010000000000,
    S_RS_CALC   = 12'b100000000000
  } state_t;

  state_t            state;
  cmd_t              req;
  logic [TABLE_DEPTH-1:0] used;
  logic [31:0]       next_number;
  logic [IW:0]       scan_cnt;
  logic              proc_valid;
  logic [IW-1:0]     proc_idx;
  logic              match;
  logic              free_found;
  logic [IW-1:0]     free_idx;
  logic              best_found;
  logic [IW-1:0]     best_idx;
  entry_t            best;
  logic              have;
  logic [DL_W-1:0]   prev;
  logic [41:0]       prod;
  logic [DL_W-1:0]   t;
  logic [NW-1:0]     n;
  logic [NW-1:0]     k;
  logic [IW-1:0]     fired [FIRE_LIMIT];
  entry_t            cur;
  logic              rs_phase;   // 0 multiply, 1 add and start pass
  logic              rs_scan;    // reschedule pass running

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;
  entry_t            d;
  logic              in_scan;
  logic              pass_end;
  logic [DL_W-1:0]   now50;
  logic [31:0]       runs_new;
  logic              keep;
  logic [NW-1:0]     k_inc;

  assign d       = entry_t'(ram_rdata);
  assign busy    = (state != S_IDLE);
  assign in_scan = (state == S_POST_SCAN) || (state == S_CAN_SCAN) ||
                   (state == S_WALK_SCAN) || (state == S_RS_CALC && rs_scan);
  assign pass_end = proc_valid && (proc_idx == IW'(TABLE_DEPTH - 1));
  assign now50    = {2'b00, req.now_time};
  assign runs_new = d.runs_done + 32'd1;
  assign keep     = d.periodic || (runs_new < d.runs_allowed);
  assign k_inc    = k + NW'(1);

  // write port and read address selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = best;
    ram_raddr = scan_cnt[IW-1:0];
    case (state)
      S_POST_END: begin
        ram_we    = free_found && !match;
        ram_waddr = free_idx;
        ram_wdata = '{dl: t, num: next_number, periodic: req.is_periodic,
                      runs_done: 32'd0, runs_allowed: req.run_limit,
                      interval: req.interval_us, cancelled: 1'b0};
      end
      S_CAN_END: begin
        ram_we              = best_found;
        ram_wdata.cancelled = 1'b1;
      end
      S_RS_RD: begin
        ram_raddr = fired[k[FW-1:0]];
      end
      S_RS_CALC: begin
        // write back only once a pass has found the deadline free
        if (rs_phase && !rs_scan && !match && scan_cnt != '0) begin
          ram_we       = 1'b1;
          ram_waddr    = fired[k[FW-1:0]];
          ram_wdata    = cur;
          ram_wdata.dl = t;
        end
      end
      default: begin
      end
    endcase
  end

  ttq_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      strobe      <= 1'b0;
      used        <= '0;
      next_number <= '0;
      scan_cnt    <= '0;
      proc_valid  <= 1'b0;
      rs_phase    <= 1'b0;
      rs_scan     <= 1'b0;
    end else begin
      strobe     <= 1'b0;
      proc_valid <= 1'b0;

      // read issue during a pass
      if (in_scan && scan_cnt < (IW+1)'(TABLE_DEPTH)) begin
        proc_valid <= 1'b1;
        proc_idx   <= scan_cnt[IW-1:0];
        scan_cnt   <= scan_cnt + (IW+1)'(1);
      end

      // per-slot compare as read data returns
      if (in_scan && proc_valid) begin
        if (used[proc_idx] && d.dl == t) begin
          match <= 1'b1;
        end
        if (!used[proc_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= proc_idx;
        end
        if (state == S_CAN_SCAN && used[proc_idx] && d.num == req.cancel_id &&
            (!best_found || d.dl < best.dl)) begin
          best_found <= 1'b1;
          best_idx   <= proc_idx;
          best       <= d;
        end
        if (state == S_WALK_SCAN && used[proc_idx] && (!have || d.dl > prev) &&
            (!best_found || d.dl < best.dl)) begin
          best_found <= 1'b1;
          best_idx   <= proc_idx;
          best       <= d;
        end
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            req        <= cmd;
            scan_cnt   <= '0;
            match      <= 1'b0;
            free_found <= 1'b0;
            best_found <= 1'b0;
            have       <= 1'b0;
            n          <= '0;
            case (cmd.action)
              ACT_POST:   state <= S_POST_MUL;
              ACT_CANCEL: state <= S_CAN_SCAN;
              ACT_TICK:   state <= S_WALK_SCAN;
              default:    state <= S_IDLE;
            endcase
          end
        end

        S_POST_MUL: begin
          prod  <= {10'b0, req.delay_us} * 42'(NS_PER_US);
          state <= S_POST_ADD;
        end

        S_POST_ADD: begin
          t     <= now50 + {8'b0, prod};
          state <= S_POST_SCAN;
        end

        S_POST_SCAN: begin
          if (pass_end) state <= S_POST_END;
        end

        // full table, collision retry or store
        S_POST_END: begin
          if (!free_found) begin
            strobe <= 1'b1;
            result <= '{kind: KIND_REJECTED, task_id: 32'd0, last: 1'b1};
            state  <= S_IDLE;
          end else if (match) begin
            t          <= t + DL_W'(1);
            match      <= 1'b0;
            free_found <= 1'b0;
            scan_cnt   <= '0;
            state      <= S_POST_SCAN;
          end else begin
            used[free_idx] <= 1'b1;
            next_number    <= next_number + 32'd1;
            strobe         <= 1'b1;
            result         <= '{kind: KIND_POSTED, task_id: next_number, last: 1'b1};
            state          <= S_IDLE;
          end
        end

        S_CAN_SCAN: begin
          if (pass_end) state <= S_CAN_END;
        end

        S_CAN_END: begin
          strobe <= 1'b1;
          if (best_found) begin
            result <= '{kind: KIND_CANCELLED, task_id: req.cancel_id, last: 1'b1};
          end else begin
            result <= '{kind: KIND_NOT_FOUND, task_id: 32'd0, last: 1'b1};
          end
          state <= S_IDLE;
        end

        S_WALK_SCAN: begin
          if (pass_end) state <= S_WALK_END;
        end

        // one step of the deadline-order walk
        S_WALK_END: begin
          if (!best_found || (!best.cancelled && best.dl > now50)) begin
            if (n == '0) begin
              strobe <= 1'b1;
              result <= '{kind: KIND_TICK_IDLE, task_id: 32'd0, last: 1'b1};
              state  <= S_IDLE;
            end else begin
              k     <= '0;
              state <= S_RS_RD;
            end
          end else begin
            have       <= 1'b1;
            prev       <= best.dl;
            best_found <= 1'b0;
            scan_cnt   <= '0;
            if (best.cancelled) begin
              used[best_idx] <= 1'b0;
              state          <= S_WALK_SCAN;
            end else begin
              fired[n[FW-1:0]] <= best_idx;
              n                <= n + NW'(1);
              if (n + NW'(1) == NW'(FIRE_LIMIT)) begin
                k     <= '0;
                state <= S_RS_RD;
              end else begin
                state <= S_WALK_SCAN;
              end
            end
          end
        end

        S_RS_RD: begin
          state <= S_RS_CAP;
        end

        // report the fired task, count its run and free it unless it is kept
        S_RS_CAP: begin
          strobe <= 1'b1;
          result <= '{kind: KIND_FIRED, task_id: d.num, last: (k_inc == n)};
          cur    <= '{dl: d.dl, num: d.num, periodic: d.periodic,
                      runs_done: runs_new, runs_allowed: d.runs_allowed,
                      interval: d.interval, cancelled: d.cancelled};
          if (keep) begin
            rs_phase <= 1'b0;
            rs_scan  <= 1'b0;
            scan_cnt <= '0;
            match    <= 1'b0;
            state    <= S_RS_CALC;
          end else begin
            used[fired[k[FW-1:0]]] <= 1'b0;
            if (k_inc == n) begin
              state <= S_IDLE;
            end else begin
              k     <= k_inc;
              state <= S_RS_RD;
            end
          end
        end

        // new deadline: multiply, add, then uniqueness passes
        S_RS_CALC: begin
          if (!rs_phase) begin
            prod     <= {10'b0, cur.interval} * 42'(NS_PER_US);
            rs_phase <= 1'b1;
          end else if (rs_scan) begin
            if (pass_end) rs_scan <= 1'b0;
          end else if (!match && scan_cnt == '0) begin
            t        <= now50 + {8'b0, prod};
            match    <= 1'b0;
            rs_scan  <= 1'b1;
          end else if (match) begin
            t        <= t + DL_W'(1);
            match    <= 1'b0;
            scan_cnt <= '0;
            rs_scan  <= 1'b1;
          end else begin
            scan_cnt <= '0;
            if (k_inc == n) begin
              state <= S_IDLE;
            end else begin
              k     <= k_inc;
              state <= S_RS_RD;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[bench/timed_task_queue_tb.sv]
module timed_task_queue_tb;
  import ttq_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int FIRE_MAX = (DEF_BATCH < MAX_RESULTS) ? DEF_BATCH : MAX_RESULTS;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // predictor of the task table and checker of results
  class task_table_sb;
    bit              used[DEPTH];
    bit [DL_W-1:0]   deadline[DEPTH];
    bit [31:0]       number[DEPTH];
    bit              periodic[DEPTH];
    bit [31:0]       runs_done[DEPTH];
    bit [31:0]       runs_allowed[DEPTH];
    bit [31:0]       interval[DEPTH];
    bit              cancelled[DEPTH];
    bit [31:0]       next_number;
    result_t         pending[$];
    int              errors;

    function bit taken(bit [DL_W-1:0] t);
      foreach (used[i]) if (used[i] && deadline[i] == t) return 1;
      return 0;
    endfunction

    function bit [DL_W-1:0] make_unique(bit [DL_W-1:0] t);
      while (taken(t)) t = t + 1'b1;
      return t;
    endfunction

    // smallest used deadline above prev
    function int next_slot(bit have, bit [DL_W-1:0] prev);
      int best;
      best = -1;
      foreach (used[i]) begin
        if (!used[i]) continue;
        if (have && deadline[i] <= prev) continue;
        if (best < 0 || deadline[i] < deadline[best]) best = i;
      end
      return best;
    endfunction

    function void add(logic [2:0] k, logic [31:0] id, logic l);
      result_t r;
      r.kind = k;
      r.task_id = id;
      r.last = l;
      pending.push_back(r);
    endfunction

    function int free_count();
      int n;
      n = 0;
      foreach (used[i]) if (!used[i]) n++;
      return n;
    endfunction

    function void note_cmd(cmd_t c);
      int s, fs, n;
      bit have;
      bit [DL_W-1:0] prev;
      int fired[$];
      have = 0;
      prev = '0;
      case (c.action)
        ACT_POST: begin
          fs = -1;
          foreach (used[i]) if (!used[i] && fs < 0) fs = i;
          if (fs < 0) begin
            add(KIND_REJECTED, 32'd0, 1'b1);
          end else begin
            deadline[fs] = make_unique(DL_W'({2'b0, c.now_time}) +
                                       DL_W'(c.delay_us) * DL_W'(NS_PER_US));
            used[fs] = 1;
            number[fs] = next_number;
            periodic[fs] = c.is_periodic;
            runs_done[fs] = 0;
            runs_allowed[fs] = c.run_limit;
            interval[fs] = c.interval_us;
            cancelled[fs] = 0;
            add(KIND_POSTED, next_number, 1'b1);
            next_number++;
          end
        end
        ACT_CANCEL: begin
          forever begin
            s = next_slot(have, prev);
            if (s < 0) break;
            if (number[s] == c.cancel_id) begin
              cancelled[s] = 1;
              add(KIND_CANCELLED, c.cancel_id, 1'b1);
              return;
            end
            have = 1;
            prev = deadline[s];
          end
          add(KIND_NOT_FOUND, 32'd0, 1'b1);
        end
        ACT_TICK: begin
          forever begin
            s = next_slot(have, prev);
            if (s < 0) break;
            have = 1;
            prev = deadline[s];
            if (cancelled[s]) begin
              used[s] = 0;
              continue;
            end
            if (deadline[s] > DL_W'(c.now_time)) break;
            fired.push_back(s);
            if (fired.size() >= FIRE_MAX) break;
          end
          n = fired.size();
          if (n == 0) add(KIND_TICK_IDLE, 32'd0, 1'b1);
          for (int k = 0; k < n; k++) begin
            s = fired[k];
            add(KIND_FIRED, number[s], k == n - 1);
            runs_done[s]++;
            if (periodic[s] || runs_done[s] < runs_allowed[s])
              deadline[s] = make_unique(DL_W'(c.now_time) +
                                        DL_W'(interval[s]) * DL_W'(NS_PER_US));
            else
              used[s] = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t r);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d task_id=%0d", r.kind, r.task_id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r.kind !== e.kind) begin
        $error("kind: expected %0d actual %0d", e.kind, r.kind);
        errors++;
      end
      if (r.task_id !== e.task_id) begin
        $error("task_id: expected %0d actual %0d", e.task_id, r.task_id);
        errors++;
      end
      if (r.last !== e.last) begin
        $error("last: expected %0d actual %0d", e.last, r.last);
        errors++;
      end
    endfunction
  endclass

  logic    clk = 0;
  logic    rst = 1;
  logic    start = 0;
  logic    busy;
  cmd_t    cmd = '0;
  logic    strobe;
  result_t result;

  task_table_sb sb = new();
  logic [47:0] clock_ns = 0;
  bit [31:0] recent_ids[$];

  timed_task_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .strobe(strobe), .result(result)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) sb.check_result(result);
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
    repeat (n) @(posedge clk);
  endtask

  // send one transaction, waiting for the handshake
  task automatic send(cmd_t c);
    start <= 1;
    cmd <= c;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_cmd(c);
    start <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  function automatic cmd_t mk_post(bit [31:0] dly, bit [31:0] ivl, bit per, bit [31:0] lim);
    cmd_t c;
    c = '0;
    c.action = ACT_POST;
    c.now_time = clock_ns;
    c.delay_us = dly;
    c.interval_us = ivl;
    c.is_periodic = per;
    c.run_limit = lim;
    c.cancel_id = $urandom;
    return c;
  endfunction

  function automatic cmd_t mk_cancel(bit [31:0] id);
    cmd_t c;
    c = '0;
    c.action = ACT_CANCEL;
    c.now_time = clock_ns;
    c.delay_us = $urandom;
    c.cancel_id = id;
    return c;
  endfunction

  function automatic cmd_t mk_tick();
    cmd_t c;
    c = '0;
    c.action = ACT_TICK;
    c.now_time = clock_ns;
    c.interval_us = $urandom;
    c.run_limit = $urandom;
    return c;
  endfunction

  task automatic send_post(cmd_t c);
    if (sb.free_count() > 0) recent_ids.push_back(sb.next_number);
    if (recent_ids.size() > 40) void'(recent_ids.pop_front());
    send(c);
  endtask

  initial begin
    cmd_t c;
    int r;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zero run limit, collisions, cancels, empty tick
    send(mk_tick());
    send_post(mk_post(0, 0, 0, 0));
    send_post(mk_post(0, 0, 0, 0));
    send_post(mk_post(0, 1, 1, 0));
    send_post(mk_post(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF));
    send(mk_cancel(1));
    send(mk_cancel(1));
    send(mk_cancel(32'hFFFF_FFFF));
    send(mk_tick());
    send(mk_tick());
    c = mk_post(0, 0, 0, 0);
    c.action = ACT_UNUSED;
    send(c);
    drain();
    // fill table with due tasks, then overflow, then batch-limited ticks
    for (int i = 0; i < DEPTH; i++) send_post(mk_post(0, 0, 0, 2));
    send_post(mk_post(5, 5, 1, 3));
    send(mk_cancel(10));
    send(mk_tick());
    send(mk_tick());
    drain();
    clock_ns = 48'hFFFF_FFFF_F000;
    send_post(mk_post(32'hFFFF_FFFF, 0, 0, 1));
    send(mk_tick());
    for (int i = 0; i < 12; i++) send(mk_tick());
    drain();
    clock_ns = 0;

    // random: mostly well-formed posts, cancels of known tasks, ticks
    for (int i = 0; i < 150; i++) begin
      clock_ns = clock_ns + $urandom_range(0, 3000);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        c = mk_post($urandom_range(0, 4), $urandom_range(0, 3),
                    1'($urandom_range(0, 1)), $urandom_range(0, 4));
        if ($urandom_range(0, 9) == 0) begin
          c.delay_us = $urandom;
          c.interval_us = $urandom;
          c.run_limit = $urandom;
        end
        send_post(c);
      end else if (r < 60) begin
        if (recent_ids.size() > 0 && $urandom_range(0, 4) != 0)
          send(mk_cancel(recent_ids[$urandom_range(0, recent_ids.size() - 1)]));
        else
          send(mk_cancel($urandom));
      end else if (r < 97) begin
        send(mk_tick());
      end else begin
        c = mk_tick();
        c.action = ACT_UNUSED;
        send(c);
      end
      if (i == 75) drain();
      else idle_gap();
    end

    // flush everything out, periodic tasks included
    for (int i = 0; i < DEPTH; i++) send(mk_cancel(sb.number[i]));
    clock_ns = 48'hFFFF_FFFF_FFFF;
    send(mk_tick());
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    repeat (100) #50000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
